// ===== rtl/gsrc_pkg.sv =====
package gsrc_pkg;

   localparam int SAMPLE_W   = 10;
   localparam int RS_W       = 26;
   localparam int SUM_W      = 32;
   localparam int RATIO_W    = 16;
   localparam int CAR_W      = 12;
   localparam int LEVEL_W    = 16;
   localparam int QUAL_W     = 3;
   localparam int TREND_W    = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int RS_FRAC    = 16;
   localparam int RATIO_FRAC = 8;

   // The shared divider covers the widest dividend, (mean << 8) and
   // (filtered << 8), and the widest divisor, the reference.
   localparam int DIV_NUM_W = RS_W + RATIO_FRAC;
   localparam int DIV_DEN_W = RS_W;

   localparam int CAL_SAMPLES_DEFAULT = 64;

   localparam logic [SAMPLE_W-1:0] ADC_FULL = 10'd1023;
   localparam int FILT_DEN   = 10;
   localparam int FILT_ROUND = 5;

   localparam logic [CAR_W-1:0]   CAR_RESET       = 12'd922;
   localparam logic [LEVEL_W-1:0] EXCELLENT_RESET = 16'd768;
   localparam logic [LEVEL_W-1:0] GOOD_RESET      = 16'd512;
   localparam logic [LEVEL_W-1:0] FAIR_RESET      = 16'd384;
   localparam logic [LEVEL_W-1:0] POOR_RESET      = 16'd256;
   localparam logic [LEVEL_W-1:0] BAND_RESET      = 16'd26;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CLEAN_AIR = 3'd0,
      CSR_EXCELLENT = 3'd1,
      CSR_GOOD      = 3'd2,
      CSR_FAIR      = 3'd3,
      CSR_POOR      = 3'd4,
      CSR_BAND      = 3'd5
   } csr_index_type;

   typedef enum logic [QUAL_W-1:0] {
      QUAL_CRITICAL  = 3'd0,
      QUAL_POOR      = 3'd1,
      QUAL_FAIR      = 3'd2,
      QUAL_GOOD      = 3'd3,
      QUAL_EXCELLENT = 3'd4
   } quality_type;

   typedef enum logic [TREND_W-1:0] {
      TREND_STABLE = 2'd0,
      TREND_RISE   = 2'd1,
      TREND_FALL   = 2'd2
   } trend_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RS,
      ST_MEAN,
      ST_REF,
      ST_FILT,
      ST_RATIO,
      ST_GRADE,
      ST_CAL_OUT
   } state_type;

   typedef struct packed {
      logic [CAR_W-1:0]   clean_air;
      logic [LEVEL_W-1:0] excellent;
      logic [LEVEL_W-1:0] good;
      logic [LEVEL_W-1:0] fair;
      logic [LEVEL_W-1:0] poor;
      logic [LEVEL_W-1:0] band;
   } cfg_type;

endpackage

// ===== rtl/gsrc_div.sv =====
module gsrc_div #(
   parameter int NUM_W = gsrc_pkg::DIV_NUM_W,
   parameter int DEN_W = gsrc_pkg::DIV_DEN_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);

   localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

   // The dividend shifts out at the top of work_ff while quotient bits
   // shift in at the bottom, one bit per cycle.
   logic [NUM_W-1:0] work_ff, work_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DEN_W:0]   rem_shift;
   logic [DEN_W+1:0] diff;

   always_comb begin
      rem_shift = {rem_ff, work_ff[NUM_W-1]};
      diff      = {1'b0, rem_shift} - {2'b00, den_ff};
      work_in   = work_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         work_in = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DEN_W+1]) begin
            rem_in  = diff[DEN_W-1:0];
            work_in = {work_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift[DEN_W-1:0];
            work_in = {work_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = work_ff;

endmodule

// ===== rtl/gsrc_grade.sv =====
module gsrc_grade (
   input  logic [gsrc_pkg::RATIO_W-1:0] ratio,
   input  logic [gsrc_pkg::RATIO_W-1:0] prev_ratio,
   input  logic                         have_prev,
   input  gsrc_pkg::cfg_type            cfg,
   output gsrc_pkg::quality_type        quality,
   output gsrc_pkg::trend_type          trend
);

   // One extra bit keeps the dead-band sums from wrapping.
   logic [gsrc_pkg::RATIO_W:0] prev_plus_band;
   logic [gsrc_pkg::RATIO_W:0] ratio_plus_band;

   always_comb begin
      prev_plus_band  = {1'b0, prev_ratio} + {1'b0, cfg.band};
      ratio_plus_band = {1'b0, ratio} + {1'b0, cfg.band};

      priority if (ratio > cfg.excellent) begin
         quality = gsrc_pkg::QUAL_EXCELLENT;
      end else if (ratio > cfg.good) begin
         quality = gsrc_pkg::QUAL_GOOD;
      end else if (ratio > cfg.fair) begin
         quality = gsrc_pkg::QUAL_FAIR;
      end else if (ratio > cfg.poor) begin
         quality = gsrc_pkg::QUAL_POOR;
      end else begin
         quality = gsrc_pkg::QUAL_CRITICAL;
      end

      priority if (!have_prev) begin
         trend = gsrc_pkg::TREND_STABLE;
      end else if ({1'b0, ratio} > prev_plus_band) begin
         trend = gsrc_pkg::TREND_RISE;
      end else if (ratio_plus_band < {1'b0, prev_ratio}) begin
         trend = gsrc_pkg::TREND_FALL;
      end else begin
         trend = gsrc_pkg::TREND_STABLE;
      end
   end

endmodule

// ===== rtl/gas_sensor_ratio_classifier.sv =====
// Gas sensor resistance-ratio classifier.
// Input channel req_*: one 10-bit converter sample per item. Result channel
// rsp_*: one result item per input item, in order, carrying ready_res, the
// filtered ratio in Q8.8, the five-level quality class and the trend code.
// The user must write configuration through csr_we/csr_index/csr_wdata
// only while idle; the block itself does not enforce this. One bit-serial
// restoring divider of DIV_NUM_W (34) steps does all the arithmetic. A
// calibrated sample needs three divisions (resistance, filter update,
// ratio), or two when the reference is zero, and the next item can be
// accepted once its result is presented. Calibration samples need one
// division; the last one adds two more divisions for the mean and the
// reference.
// The block works on one item at a time. req_stall is low whenever the
// sequencer is idle, even while a finished result waits in the output
// register. If rsp_stall holds a result, the next one waits in its last
// state until the output register frees up.
// Synchronous reset restores the register defaults, clears calibration,
// the filter and trend history, and empties the output register.
module gas_sensor_ratio_classifier #(
   parameter int CAL_SAMPLES = gsrc_pkg::CAL_SAMPLES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [gsrc_pkg::SAMPLE_W-1:0]     req_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_ready_res,
   output logic [gsrc_pkg::RATIO_W-1:0]      rsp_ratio,
   output logic [gsrc_pkg::QUAL_W-1:0]       rsp_quality,
   output logic [gsrc_pkg::TREND_W-1:0]      rsp_trend,
   input  logic                              csr_we,
   input  logic [gsrc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gsrc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
   localparam int NUM_W = gsrc_pkg::DIV_NUM_W;
   localparam int DEN_W = gsrc_pkg::DIV_DEN_W;
   localparam int RS_W  = gsrc_pkg::RS_W;
   localparam int RAT_W = gsrc_pkg::RATIO_W;

   gsrc_pkg::state_type         state_ff, state_in;
   gsrc_pkg::cfg_type           cfg_ff, cfg_in;
   logic [gsrc_pkg::SUM_W-1:0]  cal_sum_ff, cal_sum_in;
   logic [CNT_W-1:0]            cal_count_ff, cal_count_in;
   logic                        calibrated_ff, calibrated_in;
   logic [RS_W-1:0]             reference_ff, reference_in;
   logic [RS_W-1:0]             filtered_ff, filtered_in;
   logic [RAT_W-1:0]            prev_ratio_ff, prev_ratio_in;
   logic                        have_prev_ff, have_prev_in;
   logic [RAT_W-1:0]            ratio_ff, ratio_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_ready_res_ff, rsp_ready_res_in;
   logic [RAT_W-1:0]            rsp_ratio_ff, rsp_ratio_in;
   logic [gsrc_pkg::QUAL_W-1:0] rsp_quality_ff, rsp_quality_in;
   logic [gsrc_pkg::TREND_W-1:0] rsp_trend_ff, rsp_trend_in;

   logic                        div_start;
   logic [NUM_W-1:0]            div_num;
   logic [DEN_W-1:0]            div_den;
   logic                        div_done;
   logic [NUM_W-1:0]            div_quo;

   gsrc_pkg::quality_type       grade_quality;
   gsrc_pkg::trend_type         grade_trend;

   logic                        req_accept;
   logic                        out_free;
   logic [gsrc_pkg::SAMPLE_W-1:0] sample_fix;
   logic [gsrc_pkg::SAMPLE_W-1:0] rs_top;
   logic [RS_W-1:0]             rs;
   logic [CNT_W-1:0]            cal_count_next;
   logic [gsrc_pkg::SUM_W-1:0]  cal_sum_next;
   logic [gsrc_pkg::CAR_W-1:0]  car_fix;
   logic [NUM_W-1:0]            filt_num;

   gsrc_div #(
      .NUM_W(NUM_W),
      .DEN_W(DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   gsrc_grade u_grade (
      .ratio      (ratio_ff),
      .prev_ratio (prev_ratio_ff),
      .have_prev  (have_prev_ff),
      .cfg        (cfg_ff),
      .quality    (grade_quality),
      .trend      (grade_trend)
   );

   assign req_stall  = (state_ff != gsrc_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            gsrc_pkg::CSR_CLEAN_AIR: cfg_in.clean_air = csr_wdata[gsrc_pkg::CAR_W-1:0];
            gsrc_pkg::CSR_EXCELLENT: cfg_in.excellent = csr_wdata;
            gsrc_pkg::CSR_GOOD:      cfg_in.good      = csr_wdata;
            gsrc_pkg::CSR_FAIR:      cfg_in.fair      = csr_wdata;
            gsrc_pkg::CSR_POOR:      cfg_in.poor      = csr_wdata;
            gsrc_pkg::CSR_BAND:      cfg_in.band      = csr_wdata;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      sample_fix     = (req_sample == '0) ? gsrc_pkg::SAMPLE_W'(1) : req_sample;
      rs_top         = gsrc_pkg::ADC_FULL - sample_fix;
      rs             = div_quo[RS_W-1:0];
      cal_count_next = cal_count_ff + 1'b1;
      cal_sum_next   = cal_sum_ff + gsrc_pkg::SUM_W'(rs);
      car_fix        = (cfg_ff.clean_air == '0) ? gsrc_pkg::CAR_W'(1) : cfg_ff.clean_air;
      // 9 * filtered + rs + 5, the rounded numerator of the average update.
      filt_num       = NUM_W'({filtered_ff, 3'b000}) + NUM_W'(filtered_ff)
                       + NUM_W'(rs) + NUM_W'(gsrc_pkg::FILT_ROUND);

      state_in         = state_ff;
      div_start        = 1'b0;
      div_num          = '0;
      div_den          = '0;
      cal_sum_in       = cal_sum_ff;
      cal_count_in     = cal_count_ff;
      calibrated_in    = calibrated_ff;
      reference_in     = reference_ff;
      filtered_in      = filtered_ff;
      prev_ratio_in    = prev_ratio_ff;
      have_prev_in     = have_prev_ff;
      ratio_in         = ratio_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_ready_res_in = rsp_ready_res_ff;
      rsp_ratio_in     = rsp_ratio_ff;
      rsp_quality_in   = rsp_quality_ff;
      rsp_trend_in     = rsp_trend_ff;

      unique case (state_ff)
         gsrc_pkg::ST_IDLE: begin
            if (req_accept) begin
               div_start = 1'b1;
               div_num   = NUM_W'({rs_top, {gsrc_pkg::RS_FRAC{1'b0}}});
               div_den   = DEN_W'(sample_fix);
               state_in  = gsrc_pkg::ST_RS;
            end
         end
         gsrc_pkg::ST_RS: begin
            if (div_done) begin
               if (!calibrated_ff) begin
                  cal_sum_in   = cal_sum_next;
                  cal_count_in = cal_count_next;
                  if (cal_count_next == CNT_W'(CAL_SAMPLES)) begin
                     div_start = 1'b1;
                     div_num   = NUM_W'(cal_sum_next);
                     div_den   = DEN_W'(CAL_SAMPLES);
                     state_in  = gsrc_pkg::ST_MEAN;
                  end else begin
                     state_in = gsrc_pkg::ST_CAL_OUT;
                  end
               end else begin
                  div_start = 1'b1;
                  div_num   = filt_num;
                  div_den   = DEN_W'(gsrc_pkg::FILT_DEN);
                  state_in  = gsrc_pkg::ST_FILT;
               end
            end
         end
         gsrc_pkg::ST_MEAN: begin
            if (div_done) begin
               div_start = 1'b1;
               div_num   = NUM_W'({div_quo[RS_W-1:0], {gsrc_pkg::RATIO_FRAC{1'b0}}});
               div_den   = DEN_W'(car_fix);
               state_in  = gsrc_pkg::ST_REF;
            end
         end
         gsrc_pkg::ST_REF: begin
            if (div_done) begin
               reference_in  = (|div_quo[NUM_W-1:RS_W]) ? '1 : div_quo[RS_W-1:0];
               calibrated_in = 1'b1;
               state_in      = gsrc_pkg::ST_CAL_OUT;
            end
         end
         gsrc_pkg::ST_FILT: begin
            if (div_done) begin
               filtered_in = div_quo[RS_W-1:0];
               if (reference_ff == '0) begin
                  ratio_in = '1;
                  state_in = gsrc_pkg::ST_GRADE;
               end else begin
                  div_start = 1'b1;
                  div_num   = NUM_W'({div_quo[RS_W-1:0], {gsrc_pkg::RATIO_FRAC{1'b0}}});
                  div_den   = reference_ff;
                  state_in  = gsrc_pkg::ST_RATIO;
               end
            end
         end
         gsrc_pkg::ST_RATIO: begin
            if (div_done) begin
               ratio_in = (|div_quo[NUM_W-1:RAT_W]) ? '1 : div_quo[RAT_W-1:0];
               state_in = gsrc_pkg::ST_GRADE;
            end
         end
         gsrc_pkg::ST_GRADE: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_ready_res_in = 1'b1;
               rsp_ratio_in     = ratio_ff;
               rsp_quality_in   = grade_quality;
               rsp_trend_in     = grade_trend;
               prev_ratio_in    = ratio_ff;
               have_prev_in     = 1'b1;
               state_in         = gsrc_pkg::ST_IDLE;
            end
         end
         gsrc_pkg::ST_CAL_OUT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_ready_res_in = 1'b0;
               rsp_ratio_in     = '0;
               rsp_quality_in   = gsrc_pkg::QUAL_CRITICAL;
               rsp_trend_in     = gsrc_pkg::TREND_STABLE;
               state_in         = gsrc_pkg::ST_IDLE;
            end
         end
         default: state_in = gsrc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= gsrc_pkg::ST_IDLE;
         cfg_ff        <= '{clean_air: gsrc_pkg::CAR_RESET,
                            excellent: gsrc_pkg::EXCELLENT_RESET,
                            good:      gsrc_pkg::GOOD_RESET,
                            fair:      gsrc_pkg::FAIR_RESET,
                            poor:      gsrc_pkg::POOR_RESET,
                            band:      gsrc_pkg::BAND_RESET};
         cal_sum_ff    <= '0;
         cal_count_ff  <= '0;
         calibrated_ff <= 1'b0;
         reference_ff  <= '0;
         filtered_ff   <= '0;
         prev_ratio_ff <= '0;
         have_prev_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cfg_ff        <= cfg_in;
         cal_sum_ff    <= cal_sum_in;
         cal_count_ff  <= cal_count_in;
         calibrated_ff <= calibrated_in;
         reference_ff  <= reference_in;
         filtered_ff   <= filtered_in;
         prev_ratio_ff <= prev_ratio_in;
         have_prev_ff  <= have_prev_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ratio_ff         <= ratio_in;
      rsp_ready_res_ff <= rsp_ready_res_in;
      rsp_ratio_ff     <= rsp_ratio_in;
      rsp_quality_ff   <= rsp_quality_in;
      rsp_trend_ff     <= rsp_trend_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ready_res = rsp_ready_res_ff;
   assign rsp_ratio     = rsp_ratio_ff;
   assign rsp_quality   = rsp_quality_ff;
   assign rsp_trend     = rsp_trend_ff;

   // Once the reference is formed, calibration never reopens.
   a_cal_sticky: assert property (@(posedge clock) disable iff (reset)
      calibrated_ff |=> calibrated_ff)
      else $error("calibration flag dropped after being set");

   // A ready result can only come from a calibrated block.
   a_ready_needs_cal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ready_res_ff |-> calibrated_ff)
      else $error("ready result presented before calibration finished");

   // Results of calibration samples carry all-zero fields.
   a_cal_result_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready_res_ff |->
         rsp_ratio_ff == '0 && rsp_quality_ff == '0 && rsp_trend_ff == '0)
      else $error("calibration result carries nonzero fields");

   // The divider only finishes while the sequencer waits for it.
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == gsrc_pkg::ST_RS || state_ff == gsrc_pkg::ST_MEAN ||
                   state_ff == gsrc_pkg::ST_REF || state_ff == gsrc_pkg::ST_FILT ||
                   state_ff == gsrc_pkg::ST_RATIO)
      else $error("divider finished outside a division state");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import gsrc_pkg::*;

   localparam int CAL_N          = CAL_SAMPLES_DEFAULT;
   localparam int NUM_REGS       = 6;
   localparam int HOLD_CYCLES    = 800;
   localparam int SETTLE_CYCLES  = 120;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int NUM_PHASES     = 8;
   localparam int PHASE_ITEMS    = 108;
   localparam int FILT_KEEP      = 9;
   localparam int FILT_DIV       = 10;
   localparam int FILT_HALF      = 5;
   localparam int MAX_REPORTS    = 10;

   localparam logic [RS_W-1:0]    RS_CEIL    = '1;
   localparam logic [RATIO_W-1:0] RATIO_CEIL = '1;

   localparam logic [SAMPLE_W-1:0] POST_CAL_SAMPLES [14] = '{
      10'd0, 10'd1, 10'd1023, 10'd1023, 10'd1022, 10'd2, 10'd512,
      10'd511, 10'd0, 10'd0, 10'd341, 10'd682, 10'd1000, 10'd24
   };

   typedef struct packed {
      logic               ready;
      logic [RATIO_W-1:0] ratio;
      quality_type        quality;
      trend_type          trend;
   } reading_type;

   // Tracks the sensor state as the block should see it and keeps the
   // readings that are owed, oldest first.
   class ratio_ledger_type;
      logic [CAR_W-1:0]   clean_air;
      logic [LEVEL_W-1:0] excellent, good, fair, poor, band;
      logic [SUM_W-1:0]   cal_sum;
      logic [6:0]         cal_count;
      logic               calibrated;
      logic [RS_W-1:0]    reference, filtered;
      logic [RATIO_W-1:0] prev_ratio;
      logic               have_prev;
      reading_type        pending[$];
      int                 failures;

      function new();
         clean_air  = CAR_RESET;
         excellent  = EXCELLENT_RESET;
         good       = GOOD_RESET;
         fair       = FAIR_RESET;
         poor       = POOR_RESET;
         band       = BAND_RESET;
         cal_sum    = '0;
         cal_count  = '0;
         calibrated = 1'b0;
         reference  = '0;
         filtered   = '0;
         prev_ratio = '0;
         have_prev  = 1'b0;
         failures   = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_CLEAN_AIR: clean_air = value[CAR_W-1:0];
            CSR_EXCELLENT: excellent = value;
            CSR_GOOD:      good = value;
            CSR_FAIR:      fair = value;
            CSR_POOR:      poor = value;
            CSR_BAND:      band = value;
            default: ;
         endcase
      endfunction

      function void note_sample(logic [SAMPLE_W-1:0] raw);
         logic [SAMPLE_W-1:0] s;
         logic [63:0]         rs, mean, wide, car;
         reading_type         want;
         s = (raw == '0) ? SAMPLE_W'(1) : raw;
         rs = (64'(ADC_FULL - s) << RS_FRAC) / 64'(s);
         want.ready   = 1'b0;
         want.ratio   = '0;
         want.quality = QUAL_CRITICAL;
         want.trend   = TREND_STABLE;
         if (!calibrated) begin
            cal_sum = cal_sum + rs[SUM_W-1:0];
            cal_count = cal_count + 7'd1;
            if (int'(cal_count) >= CAL_N) begin
               mean = 64'(cal_sum) / 64'(CAL_N);
               car = (clean_air == '0) ? 64'd1 : 64'(clean_air);
               wide = (mean << RATIO_FRAC) / car;
               reference = (wide > 64'(RS_CEIL)) ? RS_CEIL : wide[RS_W-1:0];
               calibrated = 1'b1;
            end
         end else begin
            filtered = RS_W'((64'(filtered) * FILT_KEEP + rs + FILT_HALF) / FILT_DIV);
            if (reference == '0) begin
               wide = 64'(RATIO_CEIL);
            end else begin
               wide = (64'(filtered) << RATIO_FRAC) / 64'(reference);
               if (wide > 64'(RATIO_CEIL))
                  wide = 64'(RATIO_CEIL);
            end
            want.ready = 1'b1;
            want.ratio = wide[RATIO_W-1:0];
            if (want.ratio > excellent)
               want.quality = QUAL_EXCELLENT;
            else if (want.ratio > good)
               want.quality = QUAL_GOOD;
            else if (want.ratio > fair)
               want.quality = QUAL_FAIR;
            else if (want.ratio > poor)
               want.quality = QUAL_POOR;
            if (have_prev) begin
               if (64'(want.ratio) > 64'(prev_ratio) + 64'(band))
                  want.trend = TREND_RISE;
               else if (64'(want.ratio) + 64'(band) < 64'(prev_ratio))
                  want.trend = TREND_FALL;
            end
            prev_ratio = want.ratio;
            have_prev  = 1'b1;
         end
         pending.push_back(want);
      endfunction

      function void check_reading(logic ready, logic [RATIO_W-1:0] ratio,
                                  logic [QUAL_W-1:0] quality, logic [TREND_W-1:0] trend);
         reading_type want;
         if (pending.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("%0t: result with none pending: ready %0d ratio %0d quality %0d trend %0d",
                        $time, ready, ratio, quality, trend);
            return;
         end
         want = pending.pop_front();
         if (want.ready !== ready || want.ratio !== ratio ||
             want.quality !== quality || want.trend !== trend) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display({"%0t: expected ready %0d ratio %0d quality %0d trend %0d,",
                         " got %0d %0d %0d %0d"},
                        $time, want.ready, want.ratio, want.quality, want.trend,
                        ready, ratio, quality, trend);
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [SAMPLE_W-1:0]   req_sample;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_ready_res;
   logic [RATIO_W-1:0]    rsp_ratio;
   logic [QUAL_W-1:0]     rsp_quality;
   logic [TREND_W-1:0]    rsp_trend;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ratio_ledger_type      sb = new();
   logic [CSR_DATA_W-1:0] reg_plan [NUM_REGS];
   bit                    no_idling = 1'b0;
   int unsigned           hold_asks = 0;
   int                    walk = 512;
   int unsigned           stuck_cycles = 0;

   gas_sensor_ratio_classifier dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sample    (req_sample),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_ready_res (rsp_ready_res),
      .rsp_ratio     (rsp_ratio),
      .rsp_quality   (rsp_quality),
      .rsp_trend     (rsp_trend),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (no_idling)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 93)
         return $urandom_range(1, 4);
      return $urandom_range(20, 200);
   endfunction

   // Mostly a drifting reading, so the filtered ratio rises and falls,
   // mixed with jumps across the whole range and the end values.
   function automatic logic [SAMPLE_W-1:0] next_sample(bit drift_only);
      int unsigned r;
      r = drift_only ? 0 : $urandom_range(0, 99);
      if (r < 70) begin
         if ($urandom_range(0, 49) == 0)
            walk = $urandom_range(1, 1023);
         walk = walk + int'($urandom_range(0, 80)) - 40;
         if (walk < 1)
            walk = 1;
         if (walk > 1023)
            walk = 1023;
         return SAMPLE_W'(walk);
      end
      if (r < 92)
         return SAMPLE_W'($urandom_range(0, 1023));
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return SAMPLE_W'(1);
         2:       return SAMPLE_W'(1022);
         default: return '1;
      endcase
   endfunction

   // Thresholds drawn up to twice the last ratio plus 512; unordered sets use the
   // whole 16-bit range.
   function automatic void plan_levels(bit ordered);
      logic [LEVEL_W-1:0] lv [4];
      logic [LEVEL_W-1:0] tmp;
      int unsigned        span;
      int                 i, j;
      span = 2 * int'(sb.prev_ratio) + 512;
      if (span > 65535)
         span = 65535;
      for (i = 0; i < 4; i++)
         lv[i] = ordered ? LEVEL_W'($urandom_range(0, span)) : LEVEL_W'($urandom);
      if (ordered) begin
         for (i = 0; i < 3; i++)
            for (j = 0; j < 3 - i; j++)
               if (lv[j] < lv[j+1]) begin
                  tmp = lv[j];
                  lv[j] = lv[j+1];
                  lv[j+1] = tmp;
               end
      end
      reg_plan[CSR_CLEAN_AIR] = CSR_DATA_W'($urandom);
      reg_plan[CSR_EXCELLENT] = lv[0];
      reg_plan[CSR_GOOD]      = lv[1];
      reg_plan[CSR_FAIR]      = lv[2];
      reg_plan[CSR_POOR]      = lv[3];
      reg_plan[CSR_BAND]      = ordered ? CSR_DATA_W'($urandom_range(0, 64))
                                        : CSR_DATA_W'($urandom);
   endfunction

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      sb.write_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic load_registers();
      csr_index_type idx;
      for (int i = 0; i < NUM_REGS; i++) begin
         idx = csr_index_type'(i);
         write_reg(idx, reg_plan[idx]);
      end
      csr_we <= 1'b0;
   endtask

   task automatic send_sample(logic [SAMPLE_W-1:0] value, int unsigned gap);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // The first edge lets the monitor log the last accepted item.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0)
         @(posedge clock);
   endtask

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      int unsigned stall_left, free_left, holds_served;
      stall_left   = 0;
      free_left    = 0;
      holds_served = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (holds_served != hold_asks) begin
            holds_served = hold_asks;
            stall_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else if (free_left != 0) begin
            free_left--;
            rsp_stall <= 1'b0;
         end else begin
            stall_left = pick_gap();
            free_left = $urandom_range(0, 12);
            if (stall_left != 0) begin
               stall_left--;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_sample(req_sample);
         if (rsp_valid && !rsp_stall)
            sb.check_reading(rsp_ready_res, rsp_ratio, rsp_quality, rsp_trend);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we)
            stuck_cycles = 0;
         else
            stuck_cycles++;
         if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      logic [CSR_DATA_W-1:0] car_value;
      bit                    zero_ref;
      int unsigned           n, phase;
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_sample <= '0;
      csr_we     <= 1'b0;
      csr_index  <= CSR_CLEAN_AIR;
      csr_wdata  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // The clean-air ratio only matters before calibration ends.
      case ($urandom_range(0, 5))
         0:       car_value = 16'hF000;
         1:       car_value = 16'd1;
         2:       car_value = 16'h0FFF;
         3:       car_value = CSR_DATA_W'(CAR_RESET);
         default: car_value = CSR_DATA_W'($urandom);
      endcase
      write_reg(CSR_CLEAN_AIR, car_value);
      csr_we <= 1'b0;

      // Now and then calibrate on full-scale readings only, which leaves a
      // zero reference and a saturated ratio for the rest of the run.
      zero_ref = ($urandom_range(0, 9) == 0);
      walk = $urandom_range(300, 800);
      for (n = 0; n < CAL_N; n++) begin
         if (zero_ref || n == 0)
            send_sample('1, pick_gap());
         else if (n == 1)
            send_sample(SAMPLE_W'(512), pick_gap());
         else if (n == 2)
            send_sample(SAMPLE_W'(1022), pick_gap());
         else
            send_sample(next_sample(1'b1), pick_gap());
      end
      foreach (POST_CAL_SAMPLES[i])
         send_sample(POST_CAL_SAMPLES[i], pick_gap());

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         drain();
         case (phase)
            0: begin
               foreach (reg_plan[i])
                  reg_plan[i] = '0;
               reg_plan[CSR_CLEAN_AIR] = CSR_DATA_W'($urandom);
            end
            1: begin
               foreach (reg_plan[i])
                  reg_plan[i] = '1;
            end
            2: begin
               reg_plan[CSR_CLEAN_AIR] = CSR_DATA_W'(CAR_RESET);
               reg_plan[CSR_EXCELLENT] = EXCELLENT_RESET;
               reg_plan[CSR_GOOD]      = GOOD_RESET;
               reg_plan[CSR_FAIR]      = FAIR_RESET;
               reg_plan[CSR_POOR]      = POOR_RESET;
               reg_plan[CSR_BAND]      = BAND_RESET;
            end
            5:       plan_levels(1'b0);
            default: plan_levels(1'b1);
         endcase
         load_registers();
         no_idling = (phase == 2 || phase == 6);
         // The result side holds off while items keep coming, so the
         // block backs up into its input.
         if (phase == 3)
            hold_asks++;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 4 && n == PHASE_ITEMS / 2)
               drain();
            send_sample(next_sample(1'b0), pick_gap());
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
